FILE: hw/rtl/u8u16_pkg.sv
// Shared types and constants for the UTF-8 to UTF-16 decoder.
package u8u16_pkg;

    // Byte class boundaries of a UTF-8 lead byte.
    localparam logic [7:0] SINGLE_MAX = 8'hBF;
    localparam logic [7:0] LEAD2_MAX  = 8'hDF;
    localparam logic [7:0] LEAD3_MAX  = 8'hEF;
    localparam logic [7:0] LEAD4_MAX  = 8'hF7;

    localparam int RUNE_W = 21;
    localparam int UNIT_W = 16;

    localparam logic [19:0]       SUPP_BASE  = 20'h10000;
    localparam logic [UNIT_W-1:0] HIGH_SURR  = 16'hD800;
    localparam logic [UNIT_W-1:0] LOW_SURR   = 16'hDC00;

    // Number of code units a byte produces.
    localparam logic [1:0] CNT_NONE = 2'd0;
    localparam logic [1:0] CNT_ONE  = 2'd1;
    localparam logic [1:0] CNT_TWO  = 2'd2;

    // Up to two code units produced by one byte, handed to the output buffer.
    typedef struct packed {
        logic [1:0]        cnt;
        logic [UNIT_W-1:0] unit0;
        logic [UNIT_W-1:0] unit1;
        logic              final_flag;
    } t_units;

endpackage

FILE: hw/rtl/u8u16_core.sv
// Decode core: sequence state and the single-pass byte to code unit logic.
module u8u16_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_advance,
    input  logic [7:0]         i_text_byte,
    input  logic               i_last_byte,
    output u8u16_pkg::t_units  o_units
);
    import u8u16_pkg::*;

    logic [1:0]        r_pend;
    logic [1:0]        r_slen;
    logic [RUNE_W-1:0] r_acc;
    logic [1:0]        n_pend;
    logic [1:0]        n_slen;
    logic [RUNE_W-1:0] n_acc;

    logic              pass;
    logic [1:0]        p1;
    logic [1:0]        l1;
    logic [RUNE_W-1:0] a1;
    logic [RUNE_W-1:0] af;
    logic [RUNE_W-1:0] rune;
    logic              complete;
    logic              flush;
    logic              emit;
    logic [19:0]       supp;

    always_comb begin
        pass = 1'b0;
        p1   = r_pend;
        l1   = r_slen;
        a1   = r_acc;
        if (r_pend == 2'd0) begin
            case (i_text_byte) inside
                [8'h00:SINGLE_MAX], [8'hF8:8'hFF]: begin
                    pass = 1'b1;
                    p1   = 2'd0;
                    l1   = 2'd0;
                    a1   = '0;
                end
                [8'hC0:LEAD2_MAX]: begin
                    p1 = 2'd1;
                    l1 = 2'd1;
                    a1 = {16'd0, i_text_byte[4:0]};
                end
                [8'hE0:LEAD3_MAX]: begin
                    p1 = 2'd2;
                    l1 = 2'd2;
                    a1 = {17'd0, i_text_byte[3:0]};
                end
                [8'hF0:LEAD4_MAX]: begin
                    p1 = 2'd3;
                    l1 = 2'd3;
                    a1 = {18'd0, i_text_byte[2:0]};
                end
                default: begin
                    pass = 1'b1;
                end
            endcase
            complete = 1'b0;
        end else begin
            a1       = {r_acc[RUNE_W-7:0], i_text_byte[5:0]};
            p1       = r_pend - 2'd1;
            complete = (p1 == 2'd0);
        end

        // Missing following bytes count as zero bits when the text ends early.
        flush = i_last_byte && (p1 != 2'd0);
        case (p1)
            2'd1:    af = {a1[RUNE_W-7:0], 6'd0};
            2'd2:    af = {a1[RUNE_W-13:0], 12'd0};
            2'd3:    af = {a1[RUNE_W-19:0], 18'd0};
            default: af = a1;
        endcase

        emit = complete || flush;
        rune = complete ? a1 : af;
        supp = rune[19:0] - SUPP_BASE;

        o_units.final_flag = i_last_byte;
        o_units.unit1      = LOW_SURR | {6'd0, supp[9:0]};
        if (pass) begin
            o_units.cnt   = CNT_ONE;
            o_units.unit0 = {8'd0, i_text_byte};
        end else if (emit && (l1 == 2'd3)) begin
            o_units.cnt   = CNT_TWO;
            o_units.unit0 = HIGH_SURR | {6'd0, supp[19:10]};
        end else if (emit) begin
            o_units.cnt   = CNT_ONE;
            o_units.unit0 = rune[UNIT_W-1:0];
        end else begin
            o_units.cnt   = CNT_NONE;
            o_units.unit0 = rune[UNIT_W-1:0];
        end

        if (pass || emit) begin
            n_pend = 2'd0;
            n_slen = 2'd0;
            n_acc  = '0;
        end else begin
            n_pend = p1;
            n_slen = l1;
            n_acc  = a1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 2'd0;
            r_slen <= 2'd0;
            r_acc  <= '0;
        end else if (i_advance) begin
            r_pend <= n_pend;
            r_slen <= n_slen;
            r_acc  <= n_acc;
        end
    end

endmodule

FILE: hw/rtl/u8u16_outbuf.sv
// Result register that holds up to two code units and hands them out one per word.
module u8u16_outbuf (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_load,
    input  u8u16_pkg::t_units             i_units,
    output logic                          o_free,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [u8u16_pkg::UNIT_W-1:0]  o_code_unit,
    output logic                          o_last_of_item,
    output logic                          o_final_unit
);
    import u8u16_pkg::*;

    logic [1:0]        r_cnt;
    logic              r_idx;
    logic [UNIT_W-1:0] r_unit0;
    logic [UNIT_W-1:0] r_unit1;
    logic              r_final;
    logic              last_slot;
    logic              take;

    assign o_valid   = (r_cnt != CNT_NONE);
    assign last_slot = (r_cnt == CNT_ONE) || r_idx;
    assign take      = o_valid && !i_stall;
    assign o_free    = !o_valid || (take && last_slot);

    assign o_code_unit    = r_idx ? r_unit1 : r_unit0;
    assign o_last_of_item = last_slot;
    assign o_final_unit   = last_slot && r_final;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= CNT_NONE;
            r_idx <= 1'b0;
        end else if (i_load) begin
            r_cnt <= i_units.cnt;
            r_idx <= 1'b0;
        end else if (take) begin
            if (last_slot) begin
                r_cnt <= CNT_NONE;
                r_idx <= 1'b0;
            end else begin
                r_idx <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_unit0 <= i_units.unit0;
            r_unit1 <= i_units.unit1;
            r_final <= i_units.final_flag;
        end
    end

endmodule

FILE: hw/rtl/utf8_to_utf16_decoder.sv
// Top level of the UTF-8 to UTF-16 decoder: input register, decode core, result buffer.
//
// The decoder takes one UTF-8 byte per word on the input channel, with i_last_byte
// marking the final byte of the text, and delivers UTF-16 code units on the output
// channel. Lead bytes C0-DF, E0-EF and F0-F7 open a sequence of one, two or three
// following bytes; the low six bits of each following byte are taken without checking
// that it is a real continuation byte. Any other byte seen with no sequence open is
// passed through as a single code unit. A four-byte rune is offset by 0x10000 and sent
// as a high then low surrogate. When the text ends inside a sequence, the missing bits
// are taken as zero and the unit is flushed on the last byte. Each byte is held in the
// input register and is decoded in a single pass into a two-entry result register, so
// a byte can be accepted every cycle while the output is not stalled. A byte that
// yields a surrogate pair holds the result register for two output words, which stalls
// the input; a lead byte alone yields no word. o_last_of_item flags the last unit caused
// by a byte and o_final_unit the last unit of the whole text.
module utf8_to_utf16_decoder (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [7:0]                    i_text_byte,
    input  logic                          i_last_byte,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [u8u16_pkg::UNIT_W-1:0]  o_code_unit,
    output logic                          o_last_of_item,
    output logic                          o_final_unit
);
    import u8u16_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    logic       out_free;
    logic       advance;
    logic       accept;
    t_units     units;

    // The held byte moves into the result register once that register is empty
    // or is handing out its last unit in this cycle.
    assign advance = r_in_valid && out_free;
    assign o_stall = r_in_valid && !out_free;
    assign accept  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_byte <= i_text_byte;
            r_in_last <= i_last_byte;
        end
    end

    u8u16_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (advance),
        .i_text_byte (r_in_byte),
        .i_last_byte (r_in_last),
        .o_units     (units)
    );

    u8u16_outbuf u_outbuf (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (advance),
        .i_units        (units),
        .o_free         (out_free),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_code_unit    (o_code_unit),
        .o_last_of_item (o_last_of_item),
        .o_final_unit   (o_final_unit)
    );

endmodule
